@@ hdl/sorted_priority_table_top_defines.svh @@
// ----------------------------------------------------------------------------
// sorted priority table assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_TABLE_TOP_DEFINES_SVH
`define SORTED_PRIORITY_TABLE_TOP_DEFINES_SVH

// same-cycle implication
`define SPT_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("spt check failed");

// next-cycle implication
`define SPT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("spt check failed");

`endif

@@ hdl/spt_pkg.sv @@
// ----------------------------------------------------------------------------
// sorted priority table package
// shared widths, codes and the cell control bundle
// ----------------------------------------------------------------------------
package spt_pkg;

    localparam int DEPTH_DEF = 64;
    localparam int IDENT_W   = 16;
    localparam int PRIO_W    = 8;
    localparam int STATUS_W  = 2;
    localparam int GRP_W     = 8;

    typedef enum logic [0:0] {
        OP_INSERT = 1'b0,
        OP_DELETE = 1'b1
    } t_opcode;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE    = 2'd0,
        ST_FULL    = 2'd1,
        ST_MISSING = 2'd2
    } t_status;

    typedef struct packed {
        logic                upd;
        t_opcode             op;
        logic [IDENT_W-1:0]  ident;
        logic [PRIO_W-1:0]   prio;
    } t_cell_ctl;

endpackage

@@ hdl/spt_cell.sv @@
// ----------------------------------------------------------------------------
// sorted priority table cell
// one table slot: compares against the broadcast request and shifts
// ----------------------------------------------------------------------------
module spt_cell #(
    parameter int  DEPTH = spt_pkg::DEPTH_DEF,
    parameter int  IDX   = 0,
    localparam int POS_W = $clog2(DEPTH),
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic                       i_clk,
    input  spt_pkg::t_cell_ctl         i_ctl,
    input  logic [POS_W-1:0]           i_pos,
    input  logic [CNT_W-1:0]           i_count,
    input  logic [spt_pkg::IDENT_W-1:0] i_left_ident,
    input  logic [spt_pkg::PRIO_W-1:0]  i_left_prio,
    input  logic [spt_pkg::IDENT_W-1:0] i_right_ident,
    input  logic [spt_pkg::PRIO_W-1:0]  i_right_prio,
    output logic [spt_pkg::IDENT_W-1:0] o_ident,
    output logic [spt_pkg::PRIO_W-1:0]  o_prio,
    output logic                       o_hit
);
    import spt_pkg::*;

    localparam logic [POS_W-1:0] MY_POS = POS_W'(IDX);
    localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(IDX);

    logic [IDENT_W-1:0] r_ident, n_ident;
    logic [PRIO_W-1:0]  r_prio, n_prio;
    logic               w_held;

    assign w_held = (MY_CNT < i_count);

    always_comb begin
        case (i_ctl.op)
            OP_INSERT: o_hit = !(w_held && (r_prio >= i_ctl.prio));
            OP_DELETE: o_hit = w_held && (r_ident == i_ctl.ident);
            default:   o_hit = 1'b0;
        endcase
    end

    always_comb begin
        n_ident = r_ident;
        n_prio  = r_prio;
        if (i_ctl.upd) begin
            case (i_ctl.op)
                OP_INSERT: begin
                    if (MY_POS > i_pos) begin
                        n_ident = i_left_ident;
                        n_prio  = i_left_prio;
                    end else if (MY_POS == i_pos) begin
                        n_ident = i_ctl.ident;
                        n_prio  = i_ctl.prio;
                    end
                end
                OP_DELETE: begin
                    if (MY_POS >= i_pos) begin
                        n_ident = i_right_ident;
                        n_prio  = i_right_prio;
                    end
                end
                default: begin
                    n_ident = r_ident;
                    n_prio  = r_prio;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_ident <= n_ident;
        r_prio  <= n_prio;
    end

    assign o_ident = r_ident;
    assign o_prio  = r_prio;

endmodule

@@ hdl/spt_ffs.sv @@
// ----------------------------------------------------------------------------
// sorted priority table first-hit finder
// two registered levels: lowest hit within each group, then lowest group
// ----------------------------------------------------------------------------
module spt_ffs #(
    parameter int  DEPTH = spt_pkg::DEPTH_DEF,
    localparam int POS_W = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic [DEPTH-1:0] i_hit,
    output logic             o_found,
    output logic [POS_W-1:0] o_pos
);
    import spt_pkg::*;

    localparam int NGRP   = (DEPTH + GRP_W - 1) / GRP_W;
    localparam int PAD_N  = NGRP * GRP_W;
    localparam int LI_W   = $clog2(GRP_W);
    localparam int GI_W   = (NGRP > 1) ? $clog2(NGRP) : 1;
    localparam int FULL_W = GI_W + LI_W;

    logic [PAD_N-1:0]  w_hit_pad;
    logic [NGRP-1:0]   r_any, n_any;
    logic [LI_W-1:0]   r_loc [NGRP];
    logic [LI_W-1:0]   n_loc [NGRP];
    logic              r_found, n_found;
    logic [POS_W-1:0]  r_pos, n_pos;
    logic [GI_W-1:0]   w_sel;
    logic [LI_W-1:0]   w_sel_loc;
    logic [FULL_W-1:0] w_full_pos;

    assign w_hit_pad = PAD_N'(i_hit);

    // lowest hit inside each group
    always_comb begin
        for (int g = 0; g < NGRP; g++) begin
            n_any[g] = |w_hit_pad[g*GRP_W +: GRP_W];
            n_loc[g] = '0;
            for (int k = GRP_W - 1; k >= 0; k--) begin
                if (w_hit_pad[g*GRP_W + k]) begin
                    n_loc[g] = LI_W'(k);
                end
            end
        end
    end

    // lowest group with a hit
    always_comb begin
        w_sel     = '0;
        w_sel_loc = '0;
        for (int g = NGRP - 1; g >= 0; g--) begin
            if (r_any[g]) begin
                w_sel     = GI_W'(g);
                w_sel_loc = r_loc[g];
            end
        end
        w_full_pos = {w_sel, w_sel_loc};
        n_found    = |r_any;
        n_pos      = w_full_pos[POS_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        r_any   <= n_any;
        r_loc   <= n_loc;
        r_found <= n_found;
        r_pos   <= n_pos;
    end

    assign o_found = r_found;
    assign o_pos   = r_pos;

endmodule

@@ hdl/sorted_priority_table_top.sv @@
// ----------------------------------------------------------------------------
// sorted priority table
// table of identifier and priority pairs held in descending priority order
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on i_valid / o_stall with i_opcode, i_ident and
//   i_priority_req. An insert places the entry after every held entry of
//   greater or equal priority; a delete removes the first entry holding
//   i_ident and closes the gap. Each request gives one result on
//   o_valid / i_stall: o_status, o_position and o_count.
//   The request is registered when taken, then passes the scan, the
//   two-level first-hit search and the shift of the cell row in turn; a
//   new request is taken only while idle or in the step that shifts the row.
//   A finished result waits in the output register while the next request
//   is taken; if it is still stalled when the next result is due, the
//   shift step holds and o_stall stays high.
//   Reset empties the table at once (count to zero); slot contents are not
//   cleared and there is no clearing pass.
// ----------------------------------------------------------------------------
module sorted_priority_table_top #(
    parameter int  DEPTH = spt_pkg::DEPTH_DEF,
    localparam int POS_W = $clog2(DEPTH),
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic                         i_opcode,
    input  logic [spt_pkg::IDENT_W-1:0]  i_ident,
    input  logic [spt_pkg::PRIO_W-1:0]   i_priority_req,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [spt_pkg::STATUS_W-1:0] o_status,
    output logic [POS_W-1:0]             o_position,
    output logic [CNT_W-1:0]             o_count
);
    import spt_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_PICK,
        S_APPLY
    } t_state;

    t_state             r_state, n_state;
    t_opcode            r_req_op;
    logic [IDENT_W-1:0] r_req_ident;
    logic [PRIO_W-1:0]  r_req_prio;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               r_o_valid;
    t_status            r_status, n_status;
    logic [POS_W-1:0]   r_position, n_position;
    logic [CNT_W-1:0]   r_out_count;

    logic               w_out_free;
    logic               w_accept;
    logic               w_apply;
    logic               w_upd;
    t_cell_ctl          w_ctl;
    logic               w_found;
    logic [POS_W-1:0]   w_pos;
    logic [DEPTH-1:0]   w_hit;
    logic [IDENT_W-1:0] w_ident [DEPTH];
    logic [PRIO_W-1:0]  w_prio  [DEPTH];

    assign w_out_free = !r_o_valid || !i_stall;
    assign o_stall    = !((r_state == S_IDLE) || ((r_state == S_APPLY) && w_out_free));
    assign w_accept   = i_valid && !o_stall;
    assign w_apply    = (r_state == S_APPLY) && w_out_free;

    // outcome of the request under way
    always_comb begin
        w_upd      = 1'b0;
        n_status   = ST_DONE;
        n_position = '0;
        n_count    = r_count;
        case (r_req_op)
            OP_INSERT: begin
                if (r_count == CNT_W'(DEPTH)) begin
                    n_status = ST_FULL;
                end else begin
                    w_upd      = 1'b1;
                    n_position = w_pos;
                    n_count    = r_count + CNT_W'(1);
                end
            end
            OP_DELETE: begin
                if (w_found) begin
                    w_upd      = 1'b1;
                    n_position = w_pos;
                    n_count    = r_count - CNT_W'(1);
                end else begin
                    n_status = ST_MISSING;
                end
            end
            default: begin
                n_status = ST_MISSING;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (w_accept) n_state = S_SCAN;
            S_SCAN:  n_state = S_PICK;
            S_PICK:  n_state = S_APPLY;
            S_APPLY: begin
                if (w_apply) begin
                    n_state = w_accept ? S_SCAN : S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                r_req_op    <= t_opcode'(i_opcode);
                r_req_ident <= i_ident;
                r_req_prio  <= i_priority_req;
            end
            if (w_apply) begin
                r_count     <= n_count;
                r_o_valid   <= 1'b1;
                r_status    <= n_status;
                r_position  <= n_position;
                r_out_count <= n_count;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    assign w_ctl.upd   = w_apply && w_upd;
    assign w_ctl.op    = r_req_op;
    assign w_ctl.ident = r_req_ident;
    assign w_ctl.prio  = r_req_prio;

    for (genvar c = 0; c < DEPTH; c++) begin : g_cell
        spt_cell #(
            .DEPTH (DEPTH),
            .IDX   (c)
        ) u_cell (
            .i_clk         (i_clk),
            .i_ctl         (w_ctl),
            .i_pos         (w_pos),
            .i_count       (r_count),
            .i_left_ident  (w_ident[(c == 0) ? c : c - 1]),
            .i_left_prio   (w_prio[(c == 0) ? c : c - 1]),
            .i_right_ident (w_ident[(c == DEPTH - 1) ? c : c + 1]),
            .i_right_prio  (w_prio[(c == DEPTH - 1) ? c : c + 1]),
            .o_ident       (w_ident[c]),
            .o_prio        (w_prio[c]),
            .o_hit         (w_hit[c])
        );
    end

    spt_ffs #(
        .DEPTH (DEPTH)
    ) u_ffs (
        .i_clk   (i_clk),
        .i_hit   (w_hit),
        .o_found (w_found),
        .o_pos   (w_pos)
    );

    assign o_valid    = r_o_valid;
    assign o_status   = r_status;
    assign o_position = r_position;
    assign o_count    = r_out_count;

endmodule

@@ hdl/spt_chk.sv @@
// ----------------------------------------------------------------------------
// sorted priority table port checker
// result consistency seen at the top level ports
// ----------------------------------------------------------------------------
`include "sorted_priority_table_top_defines.svh"

module spt_chk #(
    parameter int  DEPTH = spt_pkg::DEPTH_DEF,
    localparam int POS_W = $clog2(DEPTH),
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_stall,
    input logic                         o_valid,
    input logic [spt_pkg::STATUS_W-1:0] o_status,
    input logic [POS_W-1:0]             o_position,
    input logic [CNT_W-1:0]             o_count
);
    import spt_pkg::*;

    `SPT_ASSERT_SAME(a_count_bound, i_clk, i_rst_n, o_valid, o_count <= CNT_W'(DEPTH))
    `SPT_ASSERT_SAME(a_full_count, i_clk, i_rst_n, o_valid && o_status == ST_FULL, o_count == CNT_W'(DEPTH))
    `SPT_ASSERT_SAME(a_fail_pos, i_clk, i_rst_n, o_valid && (o_status == ST_FULL || o_status == ST_MISSING), o_position == '0)
    `SPT_ASSERT_SAME(a_done_pos, i_clk, i_rst_n, o_valid && o_status == ST_DONE, CNT_W'(o_position) <= o_count)
    `SPT_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_status) && $stable(o_position) && $stable(o_count))

endmodule

bind sorted_priority_table_top spt_chk #(.DEPTH(DEPTH)) u_spt_chk (.*);
